### rtl/stt_pkg.sv
package stt_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int KW_CHARS    = 7;
  localparam int PREFIX_BITS = 8 * KW_CHARS;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // scanner modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;

  // token kinds
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_ASSIGN  = 5'd1;
  localparam logic [4:0] KIND_SEMI    = 5'd2;
  localparam logic [4:0] KIND_ADD     = 5'd3;
  localparam logic [4:0] KIND_SUB     = 5'd4;
  localparam logic [4:0] KIND_MUL     = 5'd5;
  localparam logic [4:0] KIND_DIV     = 5'd6;
  localparam logic [4:0] KIND_OPEN    = 5'd7;
  localparam logic [4:0] KIND_CLOSE   = 5'd8;
  localparam logic [4:0] KIND_INT     = 5'd9;
  localparam logic [4:0] KIND_IDENT   = 5'd10;
  localparam logic [4:0] KIND_RETURN  = 5'd11;
  localparam logic [4:0] KIND_I8      = 5'd12;
  localparam logic [4:0] KIND_I16     = 5'd13;
  localparam logic [4:0] KIND_I32     = 5'd14;
  localparam logic [4:0] KIND_I64     = 5'd15;
  localparam logic [4:0] KIND_U8      = 5'd16;
  localparam logic [4:0] KIND_U16     = 5'd17;
  localparam logic [4:0] KIND_U32     = 5'd18;
  localparam logic [4:0] KIND_U64     = 5'd19;
  localparam logic [4:0] KIND_COMMENT = 5'd20;
  localparam logic [4:0] KIND_UNKNOWN = 5'd21;

  // keyword table, earliest character in the highest byte
  localparam int KW_COUNT = 10;
  localparam logic [63:0] KW_WORD [KW_COUNT] = '{
    64'h0000_7265_7475_726E, 64'h0000_0000_0000_6938, 64'h0000_0000_0069_3136,
    64'h0000_0000_0069_3332, 64'h0000_0000_0069_3634, 64'h0000_0000_0000_7538,
    64'h0000_0000_0075_3136, 64'h0000_0000_0075_3332, 64'h0000_0000_0075_3634,
    64'h0063_6F6D_6D65_6E74
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd2, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd7
  };
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    KIND_RETURN, KIND_I8, KIND_I16, KIND_I32, KIND_I64,
    KIND_U8, KIND_U16, KIND_U32, KIND_U64, KIND_COMMENT
  };

  // token queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  unk;
    logic        last;
  } tok_t;

  // one accepted character's tokens: t0 always, t1 when two is set
  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } entry_t;

  function automatic logic [15:0] fit16(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

endpackage

### rtl/stt_front.sv
module stt_front import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_char,
  output logic       push,
  output entry_t     entry
);

  logic [1:0]             mode;
  logic [OFFSET_BITS-1:0] offset;
  logic [OFFSET_BITS-1:0] word_start;
  logic [PREFIX_BITS-1:0] word_prefix;
  logic [3:0]             prefix_count;

  logic [OFFSET_BITS-1:0] offset_adv;
  logic                   is_digit, is_letter, is_space;
  logic [4:0]             op_kind;
  logic                   cont_num, cont_word;
  logic                   have_run, have_own;
  tok_t                   run_tok, own_tok;
  logic [4:0]             word_kind;

  assign offset_adv = (offset != OFF_MAX) ? offset + 1'b1 : offset;
  assign is_digit   = (text_char >= "0") && (text_char <= "9");
  assign is_letter  = ((text_char >= "a") && (text_char <= "z")) ||
                      ((text_char >= "A") && (text_char <= "Z")) || (text_char == "_");
  assign is_space   = (text_char == " ") || ((text_char >= 8'd9) && (text_char <= 8'd13));
  assign cont_num   = (mode == MODE_NUM) && is_digit;
  assign cont_word  = (mode == MODE_WORD) && (is_letter || is_digit);

  always_comb begin
    case (text_char)
      "=":     op_kind = KIND_ASSIGN;
      ";":     op_kind = KIND_SEMI;
      "+":     op_kind = KIND_ADD;
      "-":     op_kind = KIND_SUB;
      "*":     op_kind = KIND_MUL;
      "/":     op_kind = KIND_DIV;
      "(":     op_kind = KIND_OPEN;
      ")":     op_kind = KIND_CLOSE;
      default: op_kind = KIND_EOF;
    endcase
  end

  // keyword lookup; long words never match since the count goes past every length
  always_comb begin
    word_kind = KIND_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if ((KW_LEN[i] <= 4'(KW_CHARS)) && (prefix_count == KW_LEN[i]) &&
          (64'(word_prefix) == KW_WORD[i])) begin
        word_kind = KW_KIND[i];
      end
    end
  end

  always_comb begin
    have_run       = !cont_num && !cont_word && ((mode == MODE_NUM) || (mode == MODE_WORD));
    run_tok.kind   = (mode == MODE_NUM) ? KIND_INT : word_kind;
    run_tok.start  = fit16(word_start);
    run_tok.length = fit16(offset - word_start);
    run_tok.unk    = 8'd0;
    run_tok.last   = 1'b0;

    have_own       = 1'b0;
    own_tok.kind   = KIND_UNKNOWN;
    own_tok.start  = fit16(offset);
    own_tok.length = 16'd1;
    own_tok.unk    = 8'd0;
    own_tok.last   = 1'b1;
    if (!cont_num && !cont_word) begin
      if (text_char == 8'd0) begin
        have_own       = 1'b1;
        own_tok.kind   = KIND_EOF;
        own_tok.length = 16'd0;
      end else if (is_space || is_digit || is_letter) begin
        have_own = 1'b0;
      end else if (op_kind != KIND_EOF) begin
        have_own     = 1'b1;
        own_tok.kind = op_kind;
      end else begin
        have_own    = 1'b1;
        own_tok.unk = text_char;
      end
    end

    if (have_run) begin
      entry.t0      = run_tok;
      entry.t0.last = !have_own;
      entry.t1      = own_tok;
      entry.two     = have_own;
    end else begin
      entry.t0  = own_tok;
      entry.t1  = own_tok;
      entry.two = 1'b0;
    end
    push = accept && (have_run || have_own);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      offset       <= '0;
      word_start   <= '0;
      word_prefix  <= '0;
      prefix_count <= '0;
    end else if (accept) begin
      if (cont_num) begin
        offset <= offset_adv;
      end else if (cont_word) begin
        if (prefix_count < 4'(KW_CHARS)) begin
          word_prefix <= {word_prefix[PREFIX_BITS-9:0], text_char};
        end
        if (prefix_count < 4'(KW_CHARS + 1)) begin
          prefix_count <= prefix_count + 4'd1;
        end
        offset <= offset_adv;
      end else begin
        mode <= MODE_IDLE;
        if (text_char == 8'd0) begin
          offset <= '0;
        end else if (is_digit) begin
          mode       <= MODE_NUM;
          word_start <= offset;
          offset     <= offset_adv;
        end else if (is_letter) begin
          mode         <= MODE_WORD;
          word_start   <= offset;
          word_prefix  <= PREFIX_BITS'(text_char);
          prefix_count <= 4'd1;
          offset       <= offset_adv;
        end else begin
          offset <= offset_adv;
        end
      end
    end
  end

endmodule

### rtl/stt_queue.sv
module stt_queue import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t               slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full  = (count == QCNT_BITS'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

### rtl/stt_back.sv
module stt_back import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  entry_t q_head,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output tok_t   out_tok
);

  logic pend_valid;
  tok_t pend_tok;
  logic advance;

  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && !pend_valid && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (advance) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid  <= 1'b1;
        pend_valid <= q_head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_valid) begin
        out_tok <= pend_tok;
      end else if (!q_empty) begin
        out_tok  <= q_head.t0;
        pend_tok <= q_head.t1;
      end
    end
  end

endmodule

### rtl/source_text_tokenizer.sv
// Streaming tokenizer for source text.
// Input channel: one character per item on text_char (in_valid / in_ready);
// the character 0 ends the text, emits an eof token and restarts offsets at 0.
// Output channel: one token per item (out_valid / out_ready) with kind, start
// offset, length, the offending character for unknown tokens, and last_of_run
// marking the final token caused by one input character.
// Throughput: one character per cycle while out_ready holds and characters
// average at most one token each; a character that closes a pending number or
// word and carries its own token yields two tokens, which leave in order.
// The front scanner writes each token into a 4-entry token queue on the edge
// that takes the character releasing it; the back end then loads it into the
// output register once that register is empty or being read.
// When the receiver stalls, the output register holds, the queue fills, and
// in_ready drops only once the queue is full.
// Reset (synchronous, active high) clears the scanner to idle between tokens
// at offset 0 and empties the queue and the output stage.
module source_text_tokenizer import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [7:0]  unknown_char,
  output logic        last_of_run
);

  logic   accept;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_head;
  tok_t   out_tok;

  // front may accept whenever the queue has room for this character's tokens
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  stt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_char (text_char),
    .push      (q_push),
    .entry     (q_in)
  );

  stt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  stt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign token_kind   = out_tok.kind;
  assign token_start  = out_tok.start;
  assign token_length = out_tok.length;
  assign unknown_char = out_tok.unk;
  assign last_of_run  = out_tok.last;

  // queue never written while full
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("token queue overflow");

  // the first token of a pair is always followed by its partner
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> out_valid)
    else $error("second token of a character lost");

  // output stage empty right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // kinds stay within the defined codes
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_kind <= KIND_UNKNOWN))
    else $error("undefined token kind");

endmodule

### test/source_text_tokenizer_tb.sv
module source_text_tokenizer_tb;
  import stt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  // output register plus a 4-deep token queue, with margin
  localparam int DRAIN_CYCLES = 12;

  // one pending character, tagged with the idle profile it is sent under
  typedef struct {
    logic [7:0] ch;
    logic [1:0] ph;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_char = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [7:0]  unknown_char;
  logic        last_of_run;

  stim_t text_queue [$];
  tok_t  tokens_due [$];
  int    bad_tokens = 0;
  int    cycles = 0;
  logic [1:0] cur_phase = 2'd0;

  // profile 0: sender idles 15%, receiver 65%; profile 1 swapped; profile 2 no idling
  int send_gap [3] = '{15, 65, 0};
  int recv_gap [3] = '{65, 15, 0};

  // keywords plus near misses: too long, too short, wrong case, prefixed
  string vocab [20] = '{"return", "i8", "i16", "i32", "i64", "u8", "u16", "u32", "u64",
                        "comment", "commentx", "returns", "retur", "i7", "u128", "i",
                        "u", "I8", "_i8", "comments"};
  string head_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string tail_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string op_pool   = "=;+-*/()";

  // tokenizer state as seen by the checker
  logic [1:0]             scan_state = MODE_IDLE;
  logic [OFFSET_BITS-1:0] next_ofs = '0;
  logic [OFFSET_BITS-1:0] run_start = '0;
  logic [63:0]            word_bits = '0;   // first chars of the word, oldest on top
  logic [3:0]             word_len = '0;    // saturates one past the keyword limit

  source_text_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_char    (text_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .unknown_char (unknown_char),
    .last_of_run  (last_of_run)
  );

  always #5ns clk = ~clk;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [15:0] start,
                                  input logic [15:0] len, input logic [7:0] unk);
    tok_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.unk    = unk;
    t.last   = 1'b0;
    return t;
  endfunction

  // random whitespace: space, tab, newline, vertical tab, form feed, return
  function automatic logic [7:0] blank();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? 8'd32 : 8'(9 + k);
  endfunction

  // offset sticks at its maximum
  task automatic step_offset();
    if (next_ofs != OFF_MAX)
      next_ofs = next_ofs + 1'b1;
  endtask

  // Work out the tokens that one accepted character releases and queue them.
  task automatic scan_char(input logic [7:0] c);
    tok_t       found [2];
    int         n;
    logic [4:0] op;
    logic [4:0] wkind;
    n = 0;

    // a pending run either absorbs the character or is closed by it
    if (scan_state == MODE_NUM) begin
      if (is_digit(c)) begin
        step_offset();
        return;
      end
      found[n] = mk_tok(KIND_INT, 16'(run_start), 16'(next_ofs - run_start), 8'd0);
      n = n + 1;
      scan_state = MODE_IDLE;
    end else if (scan_state == MODE_WORD) begin
      if (is_letter(c) || is_digit(c)) begin
        if (word_len <= 4'(KW_CHARS)) begin
          word_bits = {word_bits[55:0], c};
          word_len  = word_len + 1'b1;
        end
        step_offset();
        return;
      end
      // an over-long word keeps a nonzero byte above the longest keyword
      case (word_bits)
        "return":  wkind = KIND_RETURN;
        "i8":      wkind = KIND_I8;
        "i16":     wkind = KIND_I16;
        "i32":     wkind = KIND_I32;
        "i64":     wkind = KIND_I64;
        "u8":      wkind = KIND_U8;
        "u16":     wkind = KIND_U16;
        "u32":     wkind = KIND_U32;
        "u64":     wkind = KIND_U64;
        "comment": wkind = KIND_COMMENT;
        default:   wkind = KIND_IDENT;
      endcase
      found[n] = mk_tok(wkind, 16'(run_start), 16'(next_ofs - run_start), 8'd0);
      n = n + 1;
      scan_state = MODE_IDLE;
    end else begin
      scan_state = MODE_IDLE;
    end

    // KIND_EOF doubles as "not an operator" here
    case (c)
      "=":     op = KIND_ASSIGN;
      ";":     op = KIND_SEMI;
      "+":     op = KIND_ADD;
      "-":     op = KIND_SUB;
      "*":     op = KIND_MUL;
      "/":     op = KIND_DIV;
      "(":     op = KIND_OPEN;
      ")":     op = KIND_CLOSE;
      default: op = KIND_EOF;
    endcase

    if (c == 8'd0) begin
      found[n] = mk_tok(KIND_EOF, 16'(next_ofs), 16'd0, 8'd0);
      n = n + 1;
      next_ofs = '0;
    end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
      step_offset();
    end else if (op != KIND_EOF) begin
      found[n] = mk_tok(op, 16'(next_ofs), 16'd1, 8'd0);
      n = n + 1;
      step_offset();
    end else if (is_digit(c)) begin
      scan_state = MODE_NUM;
      run_start  = next_ofs;
      step_offset();
    end else if (is_letter(c)) begin
      scan_state = MODE_WORD;
      run_start  = next_ofs;
      word_bits  = {56'd0, c};
      word_len   = 4'd1;
      step_offset();
    end else begin
      // anything else, high bytes included, is a one-char unknown token
      found[n] = mk_tok(KIND_UNKNOWN, 16'(next_ofs), 16'd1, c);
      n = n + 1;
      step_offset();
    end

    if (n > 0)
      found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      tokens_due.push_back(found[i]);
  endtask

  task automatic push_char(input logic [7:0] c, input logic [1:0] ph);
    stim_t s;
    s.ch = c;
    s.ph = ph;
    text_queue.push_back(s);
  endtask

  task automatic push_text(input string s, input logic [1:0] ph);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], ph);
  endtask

  // Mostly well-formed token streams with random spacing; some raw noise
  // bytes and end-of-text marks. Every character counts toward the quota.
  task automatic gen_random(input logic [1:0] ph, input int quota);
    int    made;
    int    pick;
    int    len;
    string w;
    made = 0;
    while (made < quota) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        w = vocab[$urandom_range(19)];
        push_text(w, ph);
        made += w.len();
      end else if (pick < 40) begin
        len = $urandom_range(1, 10);
        push_char(head_pool[$urandom_range(head_pool.len() - 1)], ph);
        for (int i = 1; i < len; i++)
          push_char(tail_pool[$urandom_range(tail_pool.len() - 1)], ph);
        made += len;
      end else if (pick < 55) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_char(8'(48 + $urandom_range(9)), ph);
        made += len;
      end else if (pick < 75) begin
        push_char(op_pool[$urandom_range(7)], ph);
        made++;
      end else if (pick < 86) begin
        push_char(8'($urandom_range(1, 255)), ph);
        made++;
      end else if (pick < 89) begin
        push_char(8'd0, ph);
        made++;
      end else begin
        push_char(blank(), ph);
        made++;
      end
      // half the time tokens butt up against each other
      if ($urandom_range(1) == 1) begin
        push_char(blank(), ph);
        made++;
      end
    end
  endtask

  // Sender: holds valid and payload until taken, then maybe idles.
  always @(posedge clk) begin : feed
    stim_t nxt;
    if (rst) begin
      in_valid  <= 1'b0;
      text_char <= 8'd0;
    end else if (!in_valid || in_ready) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= send_gap[text_queue[0].ph]) begin
        nxt = text_queue.pop_front();
        in_valid  <= 1'b1;
        text_char <= nxt.ch;
        cur_phase <= nxt.ph;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure follows the profile of the last character sent.
  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_gap[cur_phase]);
  end

  // Monitor: scores accepted characters, then checks accepted tokens in order.
  always @(posedge clk) begin : watch
    tok_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        scan_char(text_char);
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          bad_tokens++;
          if (bad_tokens <= 10)
            $display("%0t: unexpected token kind %0d start %0d len %0d unk %0h last %0b",
                     $time, token_kind, token_start, token_length, unknown_char,
                     last_of_run);
        end else begin
          want = tokens_due.pop_front();
          if (token_kind !== want.kind || token_start !== want.start ||
              token_length !== want.length || unknown_char !== want.unk ||
              last_of_run !== want.last) begin
            bad_tokens++;
            if (bad_tokens <= 10)
              $display({"%0t: token mismatch: expected kind %0d start %0d len %0d ",
                        "unk %0h last %0b, got kind %0d start %0d len %0d unk %0h last %0b"},
                       $time, want.kind, want.start, want.length, want.unk, want.last,
                       token_kind, token_start, token_length, unknown_char, last_of_run);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // directed: eof on empty text, a keyword, operators, int, word with
    // digits and underscore, two-result closes, high bytes, eof flushing a word
    push_char(8'd0, 2'd0);
    push_text(" i8=123;\t(a_Z9+7)-*/\n", 2'd0);
    push_char(8'h80, 2'd0);
    push_char(8'hFF, 2'd0);
    push_text("@x", 2'd0);
    push_char(8'd0, 2'd0);

    gen_random(2'd0, 440);
    gen_random(2'd1, 440);
    gen_random(2'd2, 440);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (text_queue.size() != 0 || in_valid || tokens_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_tokens == 0 && tokens_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/source_text_tokenizer.sv
test/source_text_tokenizer_tb.sv
